### hw/rtl/glyph_quad_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// Glyph quad generator assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef GLYPH_QUAD_GENERATOR_UNIT_ASSERT_SVH
`define GLYPH_QUAD_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define GQG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset
`define GQG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### hw/rtl/gqg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqg_pkg
// Types and constants shared by the glyph quad generator files.
// ----------------------------------------------------------------------------
package gqg_pkg;

    // Character that starts a new line
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Fixed-point limits
    localparam int UV_ONE  = 65536;
    localparam int POS_MAX = 8388607;
    localparam int POS_MIN = -8388608;

    // Register reset values
    localparam logic [7:0]  GPR_RST    = 8'd2;
    localparam logic [16:0] USTEP_RST  = 17'd32768;
    localparam logic [16:0] VSTEP_RST  = 17'd5041;
    localparam logic [15:0] CELL_W_RST = 16'd256;
    localparam logic [15:0] CELL_H_RST = 16'd256;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_GPR    = 3'd0,
        CFG_USTEP  = 3'd1,
        CFG_VSTEP  = 3'd2,
        CFG_CELL_W = 3'd3,
        CFG_CELL_H = 3'd4
    } t_cfg_idx;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    // Divider request and status
    typedef struct packed {
        logic       start;
        logic [7:0] dividend;
        logic [7:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quot;
        logic [7:0] rem;
    } t_div_stat;

endpackage

### hw/rtl/gqg_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqg_char_if
// Character request channel: valid/ready with kind and code.
// ----------------------------------------------------------------------------
interface gqg_char_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink   (input valid, input kind, input char_code, output ready);
endinterface

### hw/rtl/gqg_vertex_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqg_vertex_if
// Vertex request channel: valid/ready with one quad corner.
// ----------------------------------------------------------------------------
interface gqg_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [1:0]         corner;
    logic [15:0]        quad_index;
    logic               last;

    modport source (output valid, output pos_x, output pos_y, output tex_u,
                    output tex_v, output corner, output quad_index, output last,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input tex_u,
                    input tex_v, input corner, input quad_index, input last,
                    output ready);
endinterface

### hw/rtl/gqg_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqg_divider
// Restoring 8-bit by 8-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gqg_divider
    import gqg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_stat o_stat
);

    logic [7:0] r_rem;
    logic [7:0] r_quo;
    logic [7:0] r_dvs;
    logic [2:0] r_cnt;
    logic       r_busy;
    logic       r_done;

    logic [8:0] w_part;
    logic [8:0] w_trial;

    // Shift in the next dividend bit and try a subtract
    assign w_part  = {r_rem, r_quo[7]};
    assign w_trial = w_part - {1'b0, r_dvs};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_trial[8]) begin
                r_rem <= w_trial[7:0];
                r_quo <= {r_quo[6:0], 1'b1};
            end else begin
                r_rem <= w_part[7:0];
                r_quo <= {r_quo[6:0], 1'b0};
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_quo;
    assign o_stat.rem  = r_rem;

endmodule

### hw/rtl/glyph_quad_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_quad_generator_unit
// Lays out one bitmap-font atlas quad (four vertices) per character other than newline.
// ----------------------------------------------------------------------------
// A newline request produces no vertex. For any other character the accept
// comes first. Then the block waits on the bit-serial divider that finds
// the atlas cell bit by bit and then hands the result over. Then the one
// shared multiplier forms the x, y, u and v products in turn. Last, one
// vertex is loaded per cycle while the output is not stalled. The block takes
// no new character until the fourth vertex is loaded into the output
// register. Vertices come in the order up-left, down-left, down-right,
// up-right; last marks the up-right one. Registers are to be written through
// the cfg port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module glyph_quad_generator_unit
    import gqg_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gqg_char_if.sink     i_req,
    gqg_vertex_if.source o_vtx,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [16:0]  i_cfg_data
);

    localparam int CB   = COUNT_BITS;
    localparam int MA_W = CB + 1;
    localparam int MB_W = 18;
    localparam int PW   = MA_W + MB_W;
    localparam int SW   = PW + 2;

    localparam logic signed [SW-1:0] L_POS_MAX = SW'(POS_MAX);
    localparam logic signed [SW-1:0] L_POS_MIN = SW'(POS_MIN);
    localparam logic signed [SW-1:0] L_UV_ONE  = SW'(UV_ONE);
    localparam logic [CB-1:0]        LINE_MIN  = {1'b1, {(CB-1){1'b0}}};

    // Configuration registers
    logic [7:0]  r_gpr;
    logic [16:0] r_ustep;
    logic [16:0] r_vstep;
    logic [15:0] r_cw;
    logic [15:0] r_ch;

    // Layout state
    logic [CB-1:0] r_column;
    logic [CB-1:0] r_line;
    logic [CB-1:0] r_quad;

    // Working copy of the character in flight
    logic [CB-1:0] r_w_col;
    logic [CB-1:0] r_w_line;
    logic [15:0]   r_w_quad;

    // Sequencer
    t_state     r_st;
    logic [1:0] r_mstep;
    logic [1:0] r_corner;

    // Product registers
    logic signed [PW-1:0] r_xl;
    logic signed [PW-1:0] r_yd;
    logic signed [PW-1:0] r_ul;
    logic signed [PW-1:0] r_vr;

    // Output register
    logic               r_ov;
    logic signed [23:0] r_px;
    logic signed [23:0] r_py;
    logic [16:0]        r_tu;
    logic [16:0]        r_tv;
    logic [1:0]         r_oc;
    logic [15:0]        r_oq;
    logic               r_ol;

    logic          w_acc;
    logic          w_nl;
    logic [CB-1:0] w_eff_col;
    logic [CB-1:0] w_eff_line;
    logic [CB-1:0] w_eff_quad;
    logic [CB+15:0] w_quad_ext;
    logic          w_load;
    t_div_req      w_div_req;
    t_div_stat     w_div_stat;

    // Request accept and new-text clear
    assign i_req.ready = (r_st == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_nl        = (i_req.char_code == NEWLINE_CODE);
    assign w_eff_col   = i_req.kind ? '0 : r_column;
    assign w_eff_line  = i_req.kind ? '0 : r_line;
    assign w_eff_quad  = i_req.kind ? '0 : r_quad;
    assign w_quad_ext  = {16'd0, w_eff_quad};

    // Atlas cell: code divided by glyphs per row (zero acts as one)
    assign w_div_req.start    = w_acc && !w_nl;
    assign w_div_req.dividend = i_req.char_code;
    assign w_div_req.divisor  = (r_gpr == 8'd0) ? 8'd1 : r_gpr;

    gqg_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_stat (w_div_stat)
    );

    // Shared multiplier operand select
    logic signed [MA_W-1:0] w_ma;
    logic signed [MB_W-1:0] w_mb;
    logic signed [PW-1:0]   w_prod;

    always_comb begin
        case (r_mstep)
            2'd0: begin
                w_ma = $signed({1'b0, r_w_col});
                w_mb = $signed({2'b00, r_cw});
            end
            2'd1: begin
                w_ma = $signed({r_w_line[CB-1], r_w_line});
                w_mb = $signed({2'b00, r_ch});
            end
            2'd2: begin
                w_ma = $signed({{(MA_W-8){1'b0}}, w_div_stat.rem});
                w_mb = $signed({1'b0, r_ustep});
            end
            default: begin
                w_ma = $signed({{(MA_W-8){1'b0}}, w_div_stat.quot});
                w_mb = $signed({1'b0, r_vstep});
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // Vertex of the current corner
    logic                 w_right;
    logic                 w_up;
    logic signed [SW-1:0] w_x;
    logic signed [SW-1:0] w_y;
    logic signed [SW-1:0] w_u;
    logic signed [SW-1:0] w_v;
    logic signed [23:0]   w_px;
    logic signed [23:0]   w_py;
    logic [16:0]          w_tu;
    logic [16:0]          w_tv;

    assign w_right = r_corner[1];
    assign w_up    = (r_corner[0] == r_corner[1]);

    always_comb begin
        w_x = SW'(r_xl) + (w_right ? $signed({{(SW-16){1'b0}}, r_cw}) : SW'(0));
        w_y = SW'(r_yd) - (w_up ? $signed({{(SW-16){1'b0}}, r_ch}) : SW'(0));
        w_u = SW'(r_ul) + (w_right ? $signed({{(SW-17){1'b0}}, r_ustep}) : SW'(0));
        w_v = L_UV_ONE - SW'(r_vr)
            - (w_up ? $signed({{(SW-17){1'b0}}, r_vstep}) : SW'(0));

        if (w_x > L_POS_MAX)      w_px = 24'sh7FFFFF;
        else if (w_x < L_POS_MIN) w_px = 24'sh800000;
        else                      w_px = w_x[23:0];

        if (w_y > L_POS_MAX)      w_py = 24'sh7FFFFF;
        else if (w_y < L_POS_MIN) w_py = 24'sh800000;
        else                      w_py = w_y[23:0];

        if (w_u < 0)              w_tu = 17'd0;
        else if (w_u > L_UV_ONE)  w_tu = 17'h10000;
        else                      w_tu = w_u[16:0];

        if (w_v < 0)              w_tv = 17'd0;
        else if (w_v > L_UV_ONE)  w_tv = 17'h10000;
        else                      w_tv = w_v[16:0];
    end

    assign w_load = (r_st == ST_EMIT) && (!r_ov || o_vtx.ready);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpr   <= GPR_RST;
            r_ustep <= USTEP_RST;
            r_vstep <= VSTEP_RST;
            r_cw    <= CELL_W_RST;
            r_ch    <= CELL_H_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GPR:    r_gpr   <= i_cfg_data[7:0];
                CFG_USTEP:  r_ustep <= i_cfg_data;
                CFG_VSTEP:  r_vstep <= i_cfg_data;
                CFG_CELL_W: r_cw    <= i_cfg_data[15:0];
                CFG_CELL_H: r_ch    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Layout state and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_line   <= '0;
            r_quad   <= '0;
            r_st     <= ST_IDLE;
            r_mstep  <= '0;
            r_corner <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (w_load)           r_ov <= 1'b1;
            else if (o_vtx.ready) r_ov <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (w_nl) begin
                            r_column <= '0;
                            r_quad   <= w_eff_quad;
                            r_line   <= (w_eff_line != LINE_MIN) ?
                                        w_eff_line - CB'(1) : w_eff_line;
                        end else begin
                            r_column <= (&w_eff_col) ? w_eff_col : w_eff_col + CB'(1);
                            r_quad   <= (&w_eff_quad) ? w_eff_quad : w_eff_quad + CB'(1);
                            r_line   <= w_eff_line;
                            r_st     <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_stat.done) begin
                        r_st    <= ST_MUL;
                        r_mstep <= '0;
                    end
                end
                ST_MUL: begin
                    r_mstep <= r_mstep + 2'd1;
                    if (&r_mstep) begin
                        r_st     <= ST_EMIT;
                        r_corner <= '0;
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_corner <= r_corner + 2'd1;
                        if (&r_corner) r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // Working copy, taken at accept
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_w_col  <= w_eff_col;
            r_w_line <= w_eff_line;
            r_w_quad <= w_quad_ext[15:0];
        end
    end

    // Product capture, one per multiply step
    always_ff @(posedge i_clk) begin
        if (r_st == ST_MUL) begin
            case (r_mstep)
                2'd0:    r_xl <= w_prod;
                2'd1:    r_yd <= w_prod;
                2'd2:    r_ul <= w_prod;
                default: r_vr <= w_prod;
            endcase
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_px <= w_px;
            r_py <= w_py;
            r_tu <= w_tu;
            r_tv <= w_tv;
            r_oc <= r_corner;
            r_oq <= r_w_quad;
            r_ol <= &r_corner;
        end
    end

    assign o_vtx.valid      = r_ov;
    assign o_vtx.pos_x      = r_px;
    assign o_vtx.pos_y      = r_py;
    assign o_vtx.tex_u      = r_tu;
    assign o_vtx.tex_v      = r_tv;
    assign o_vtx.corner     = r_oc;
    assign o_vtx.quad_index = r_oq;
    assign o_vtx.last       = r_ol;

endmodule

### hw/rtl/gqg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqg_checker
// Port-level checks on the glyph quad generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "glyph_quad_generator_unit_assert.svh"

module gqg_checker
    import gqg_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [7:0]  i_req_code,
    input logic        i_vtx_valid,
    input logic        i_vtx_ready,
    input logic [1:0]  i_vtx_corner,
    input logic        i_vtx_last,
    input logic [23:0] i_vtx_pos_x
);

    // A glyph request keeps the block busy
    `GQG_ASSERT_NEXT(a_glyph_busy, i_clk, i_rst_n,
        i_req_valid && i_req_ready && (i_req_code != NEWLINE_CODE), !i_req_ready)

    // last marks the up-right corner only
    `GQG_ASSERT_NOW(a_last_corner, i_clk, i_rst_n,
        i_vtx_valid, i_vtx_last == (i_vtx_corner == 2'd3))

    // Mid-quad the block takes no new request
    `GQG_ASSERT_NOW(a_no_req_mid_quad, i_clk, i_rst_n,
        i_vtx_valid && (i_vtx_corner != 2'd3), !i_req_ready)

    // Next corner follows right after a taken one
    `GQG_ASSERT_NEXT(a_corner_follows, i_clk, i_rst_n,
        i_vtx_valid && i_vtx_ready && (i_vtx_corner != 2'd3), i_vtx_valid)

    // Stalled vertex holds
    `GQG_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n,
        i_vtx_valid && !i_vtx_ready,
        i_vtx_valid && $stable(i_vtx_corner) && $stable(i_vtx_pos_x))

endmodule

bind glyph_quad_generator_unit gqg_checker u_gqg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_code  (i_req.char_code),
    .i_vtx_valid (o_vtx.valid),
    .i_vtx_ready (o_vtx.ready),
    .i_vtx_corner(o_vtx.corner),
    .i_vtx_last  (o_vtx.last),
    .i_vtx_pos_x (o_vtx.pos_x)
);

### sim/tb_glyph_quad_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_quad_generator_unit
// Self-checking bench for the glyph quad generator. Character requests are
// driven with random bursts and gaps, and vertex requests are taken with a
// random stall pattern. A behavioral layout predictor computes the four
// vertices of every glyph, and each vertex taken from the block is compared
// field by field. Directed tests cover register extremes and masking, unused
// register indexes, deep negative line offsets, position clamping and a long
// output stall; random phases then run under changing register settings.
// ----------------------------------------------------------------------------
module tb_glyph_quad_generator_unit;
    import gqg_pkg::*;

    localparam int DRAIN_CYCLES = 32;
    localparam int MAX_REPORTS  = 40;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_CHARS  = 38;

    localparam logic KIND_CONT = 1'b0;
    localparam logic KIND_NEW  = 1'b1;

    localparam logic [15:0]        COUNT_TOP  = 16'hFFFF;
    localparam logic signed [15:0] LINE_FLOOR = 16'sh8000;

    typedef enum logic [1:0] {
        CORNER_UL = 2'd0,
        CORNER_DL = 2'd1,
        CORNER_DR = 2'd2,
        CORNER_UR = 2'd3
    } t_corner;

    typedef enum logic {
        SINK_OPEN   = 1'b0,
        SINK_STALLS = 1'b1
    } t_sink_mode;

    typedef struct {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [1:0]         corner;
        logic [15:0]        quad_index;
        logic               last;
    } vertex_t;

    logic i_clk;
    logic i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [16:0] i_cfg_data;

    gqg_char_if   req_if();
    gqg_vertex_if vtx_if();

    glyph_quad_generator_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_vtx      (vtx_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Layout predictor state and register copy
    logic [7:0]         reg_glyphs_per_row;
    logic [16:0]        reg_u_step;
    logic [16:0]        reg_v_step;
    logic [15:0]        reg_cell_width;
    logic [15:0]        reg_cell_height;
    logic [15:0]        pen_column;
    logic signed [15:0] pen_line;
    logic [15:0]        quad_total;

    vertex_t pending_vertices[$];

    // Sender and receiver controls
    bit         source_gaps;
    int         burst_left;
    t_sink_mode sink_mode;
    int         hold_len;
    int         hold_seq;
    int         hold_seen;
    int         hold_left;
    int         run_left;
    bit         ready_run;

    int mismatch_count;
    int chars_sent;
    int newlines_sent;
    int new_texts;
    int vertices_checked;
    int settings_used;

    // Clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Run limit
    initial begin
        #4_000_000;
        $display("glyph_quad_generator_unit: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Register copy, masked to each register's width
    function automatic void apply_reg(input logic [2:0] idx, input logic [16:0] data);
        case (idx)
            CFG_GPR:    reg_glyphs_per_row = data[7:0];
            CFG_USTEP:  reg_u_step         = data;
            CFG_VSTEP:  reg_v_step         = data;
            CFG_CELL_W: reg_cell_width     = data[15:0];
            CFG_CELL_H: reg_cell_height    = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic void push_corner(input t_corner c, input longint x, input longint y,
                                        input longint u, input longint v);
        vertex_t vx;
        vx.pos_x      = 24'(clamp(x, POS_MIN, POS_MAX));
        vx.pos_y      = 24'(clamp(y, POS_MIN, POS_MAX));
        vx.tex_u      = 17'(clamp(u, 0, UV_ONE));
        vx.tex_v      = 17'(clamp(v, 0, UV_ONE));
        vx.corner     = c;
        vx.quad_index = quad_total;
        vx.last       = (c == CORNER_UR);
        pending_vertices.push_back(vx);
    endfunction

    // Lay out one character: update pen state, queue the quad's vertices
    function automatic void lay_out_char(input logic kind, input logic [7:0] code);
        int unsigned cells, acol, arow;
        longint xl, xr, yu, yd, ul, ur, vu, vd;
        if (kind == KIND_NEW) begin
            pen_column = '0;
            pen_line   = '0;
            quad_total = '0;
        end
        if (code == NEWLINE_CODE) begin
            pen_column = '0;
            if (pen_line > LINE_FLOOR)
                pen_line--;
            return;
        end
        cells = (reg_glyphs_per_row == 0) ? 1 : reg_glyphs_per_row;
        acol  = code % cells;
        arow  = code / cells;

        xl = longint'(pen_column) * longint'(reg_cell_width);
        xr = xl + longint'(reg_cell_width);
        yd = longint'(pen_line) * longint'(reg_cell_height);
        yu = yd - longint'(reg_cell_height);
        ul = longint'(acol) * longint'(reg_u_step);
        ur = ul + longint'(reg_u_step);
        vd = longint'(UV_ONE) - longint'(arow) * longint'(reg_v_step);
        vu = vd - longint'(reg_v_step);

        push_corner(CORNER_UL, xl, yu, ul, vu);
        push_corner(CORNER_DL, xl, yd, ul, vd);
        push_corner(CORNER_DR, xr, yd, ur, vd);
        push_corner(CORNER_UR, xr, yu, ur, vu);

        if (pen_column != COUNT_TOP)
            pen_column++;
        if (quad_total != COUNT_TOP)
            quad_total++;
    endfunction

    // Send one character request; valid stays high for a following request
    task automatic send_char(input logic kind, input logic [7:0] code);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = source_gaps ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        req_if.valid     <= 1'b1;
        req_if.kind      <= kind;
        req_if.char_code <= code;
        do @(posedge i_clk); while (!req_if.ready);
        lay_out_char(kind, code);
        chars_sent++;
        if (code == NEWLINE_CODE) newlines_sent++;
        if (kind == KIND_NEW) new_texts++;
    endtask

    // Stop requesting and let every queued vertex come out
    task automatic wait_idle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write; write enable is left high for a following write
    task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [16:0] gpr, input logic [16:0] ustep,
                              input logic [16:0] vstep, input logic [16:0] cw,
                              input logic [16:0] ch);
        write_reg(CFG_GPR, gpr);
        write_reg(CFG_USTEP, ustep);
        write_reg(CFG_VSTEP, vstep);
        write_reg(CFG_CELL_W, cw);
        write_reg(CFG_CELL_H, ch);
        end_writes();
        settings_used++;
    endtask

    // Reset register values, glyphs at both ends of the code range
    task automatic test_directed_defaults();
        send_char(KIND_NEW, 8'h48);
        send_char(KIND_CONT, 8'h69);
        send_char(KIND_CONT, 8'h00);
        send_char(KIND_CONT, 8'hFF);
        send_char(KIND_CONT, NEWLINE_CODE);
        send_char(KIND_CONT, 8'h7F);
        send_char(KIND_CONT, 8'h80);
        send_char(KIND_NEW, NEWLINE_CODE);
        send_char(KIND_CONT, 8'h01);
        send_char(KIND_CONT, 8'h55);
        send_char(KIND_NEW, 8'hAA);
        wait_idle();
    endtask

    // Width masking, zero glyphs per row, unused indexes, step extremes
    task automatic test_register_extremes();
        int i;
        // glyphs_per_row masks to zero, cell height masks to zero
        set_config(17'h1FF00, 17'd65536, 17'h1FFFF, 17'h1FFFF, 17'h10000);
        for (i = int'(CFG_CELL_H) + 1; i < 8; i++)
            write_reg(3'(i), 17'h1FFFF);
        end_writes();
        send_char(KIND_NEW, 8'h00);
        send_char(KIND_CONT, 8'h01);
        send_char(KIND_CONT, 8'hFF);
        wait_idle();

        set_config(17'd255, 17'd0, 17'd0, 17'd0, 17'd65535);
        send_char(KIND_CONT, 8'hFE);
        send_char(KIND_CONT, NEWLINE_CODE);
        send_char(KIND_CONT, 8'hFF);
        send_char(KIND_CONT, 8'h00);
        wait_idle();

        set_config(17'd1, 17'h1FFFF, 17'd65536, 17'd1, 17'd1);
        send_char(KIND_CONT, 8'h80);
        send_char(KIND_CONT, 8'h03);
        wait_idle();
    endtask

    // Many newlines with tall cells: y positions clamp at the bottom of the range
    task automatic test_line_floor();
        int i;
        // the line offset floor itself takes 32768 newlines and is not run here
        set_config(17'd16, 17'd4096, 17'd4096, 17'd512, 17'd65535);
        source_gaps = 1'b0;
        send_char(KIND_NEW, NEWLINE_CODE);
        for (i = 0; i < 130; i++)
            send_char(KIND_CONT, NEWLINE_CODE);
        send_char(KIND_CONT, 8'h41);
        send_char(KIND_CONT, 8'h42);
        send_char(KIND_NEW, 8'h43);
        source_gaps = 1'b1;
        wait_idle();
    endtask

    // Long line with wide cells: x positions clamp at the top of the range
    task automatic test_position_clamp();
        int i;
        // quad counter saturation would take 65535 glyphs and is not run here
        set_config(17'd16, 17'd4096, 17'd4096, 17'd65535, 17'd300);
        send_char(KIND_NEW, 8'($urandom_range(0, 255)));
        for (i = 0; i < 134; i++)
            send_char(KIND_CONT, 8'($urandom_range(11, 255)));
        wait_idle();
    endtask

    // Output held off for a long stretch while requests keep coming
    task automatic test_backpressure();
        int i;
        set_config(17'd2, 17'd32768, 17'd5041, 17'd256, 17'd256);
        sink_mode   = SINK_OPEN;
        source_gaps = 1'b0;
        hold_len    = 300;
        hold_seq++;
        for (i = 0; i < 16; i++)
            send_char(KIND_CONT, 8'($urandom_range(0, 255)));
        source_gaps = 1'b1;
        sink_mode   = SINK_STALLS;
        wait_idle();
    endtask

    // Random text under random register settings
    task automatic test_random_phases();
        int p, i, r;
        logic [16:0] g, u, v, w, h;
        logic kind;
        logic [7:0] code;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 4))
                0:       g = 17'd0;
                1:       g = 17'd1;
                2:       g = 17'd255;
                default: g = 17'($urandom_range(1, 255));
            endcase
            case ($urandom_range(0, 5))
                0:       u = 17'd0;
                1:       u = 17'd65536;
                2:       u = 17'h1FFFF;
                default: u = 17'($urandom_range(0, 65536));
            endcase
            case ($urandom_range(0, 5))
                0:       v = 17'd0;
                1:       v = 17'd65536;
                2:       v = 17'h1FFFF;
                default: v = 17'($urandom_range(0, 4096));
            endcase
            case ($urandom_range(0, 4))
                0:       w = 17'd0;
                1:       w = 17'd65535;
                default: w = 17'($urandom_range(0, 2048));
            endcase
            case ($urandom_range(0, 4))
                0:       h = 17'd0;
                1:       h = 17'd65535;
                default: h = 17'($urandom_range(0, 2048));
            endcase
            set_config(g, u, v, w, h);

            // one phase runs with no idling on either side
            source_gaps = (p != 2);
            sink_mode   = (p == 2) ? SINK_OPEN : SINK_STALLS;

            for (i = 0; i < PHASE_CHARS; i++) begin
                r    = $urandom_range(0, 99);
                kind = (r < 5) ? KIND_NEW : KIND_CONT;
                r    = $urandom_range(0, 99);
                code = (r < 10) ? NEWLINE_CODE : 8'($urandom_range(0, 255));
                send_char(kind, code);
            end
            wait_idle();
        end
        source_gaps = 1'b1;
        sink_mode   = SINK_STALLS;
    endtask

    // Vertex receiver: long hold-offs first, then the stall pattern, or always ready when open
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left != 0) begin
            hold_left--;
            vtx_if.ready <= 1'b0;
        end else if (sink_mode == SINK_STALLS) begin
            if (run_left == 0) begin
                ready_run = !ready_run;
                run_left  = ready_run ? $urandom_range(1, 10) : $urandom_range(1, 6);
            end
            run_left--;
            vtx_if.ready <= ready_run;
        end else begin
            vtx_if.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input vertex_t want,
                               input logic signed [31:0] got_v,
                               input logic signed [31:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("quad %0d corner %0d: %s = %0d, want %0d",
                                      want.quad_index, want.corner, name, got_v, want_v));
    endtask

    // Vertex checker
    always @(posedge i_clk) begin : vertex_check
        vertex_t want;
        if (i_rst_n && vtx_if.valid && vtx_if.ready) begin
            if (pending_vertices.size() == 0) begin
                report_mismatch($sformatf("vertex with none pending: quad %0d corner %0d",
                                          vtx_if.quad_index, vtx_if.corner));
            end else begin
                want = pending_vertices.pop_front();
                check_field("pos_x", want, vtx_if.pos_x, want.pos_x);
                check_field("pos_y", want, vtx_if.pos_y, want.pos_y);
                check_field("tex_u", want, vtx_if.tex_u, want.tex_u);
                check_field("tex_v", want, vtx_if.tex_v, want.tex_v);
                check_field("corner", want, vtx_if.corner, want.corner);
                check_field("quad_index", want, vtx_if.quad_index, want.quad_index);
                check_field("last", want, vtx_if.last, want.last);
                vertices_checked++;
            end
        end
    end

    // Test sequence
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_GPR;
        i_cfg_data       = '0;
        req_if.valid     = 1'b0;
        req_if.kind      = KIND_CONT;
        req_if.char_code = '0;
        vtx_if.ready     = 1'b0;
        source_gaps      = 1'b1;
        sink_mode        = SINK_STALLS;

        reg_glyphs_per_row = GPR_RST;
        reg_u_step         = USTEP_RST;
        reg_v_step         = VSTEP_RST;
        reg_cell_width     = CELL_W_RST;
        reg_cell_height    = CELL_H_RST;
        pen_column         = '0;
        pen_line           = '0;
        quad_total         = '0;
        settings_used      = 1;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_defaults();
        test_register_extremes();
        test_line_floor();
        test_position_clamp();
        test_backpressure();
        test_random_phases();

        $display("Run covered %0d characters (%0d newlines, %0d new texts) over %0d settings,",
                 chars_sent, newlines_sent, new_texts, settings_used);
        $display("with %0d vertices compared and %0d mismatches.",
                 vertices_checked, mismatch_count);
        if (mismatch_count == 0 && pending_vertices.size() == 0) begin
            $display("glyph_quad_generator_unit: match");
        end else begin
            $display("glyph_quad_generator_unit: mismatch");
        end
        $finish;
    end

endmodule
